/* sv/first_fit_block_allocator_assert.svh */
// Assertion macros shared by the allocator modules.
// They expect clk and rst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`define FFBA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define FFBA_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/ffba_pkg.sv */
package ffba_pkg;

    localparam int HEAP_BYTES        = 65536;
    localparam int MAX_BLOCKS        = 64;
    localparam int HEADER_BYTES      = 24;
    localparam int FOOTER_BYTES      = 4;
    localparam int HEAP_HEADER_BYTES = 8;

    localparam int TBL_AW = 6;    // table address bits
    localparam int CNT_W  = 7;    // block count, holds MAX_BLOCKS itself
    localparam int SZ_W   = 17;   // offsets and sizes
    localparam int Q_DEPTH = 2;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_DOUBLE  = 3'd2,
        ST_INVALID = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic [SZ_W-1:0] offset;
        logic [SZ_W-1:0] size;
        logic            is_free;
    } blk_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [SZ_W-1:0] need;
        logic [15:0]     paddr;
    } q_item_t;

endpackage

/* sv/ffba_front.sv */
`include "first_fit_block_allocator_assert.svh"

module ffba_front
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [15:0] req_size,
    input  logic [15:0] payload_addr,
    output logic        q_valid,
    output q_item_t     q_item,
    input  logic        q_pop
);

    q_item_t    q_mem_reg [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    q_item_t    new_item;

    assign in_ready = (cnt_reg != 2'(Q_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // The footer is added to the request here, so the engine sees the real need.
    always_comb
    begin
        new_item.cmd   = cmd_t'(cmd);
        new_item.need  = SZ_W'(req_size) + SZ_W'(FOOTER_BYTES);
        new_item.paddr = payload_addr;
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next       = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `FFBA_ASSERT(a_cnt_bound, cnt_reg <= 2'(Q_DEPTH), "queue count beyond depth")
    `FFBA_IMPLY(a_full_stall, !in_ready, q_valid, "stalled with an empty queue")
    `FFBA_IMPLY(a_pop_valid, q_pop, q_valid, "pop from an empty queue")

endmodule

/* sv/ffba_engine.sv */
`include "first_fit_block_allocator_assert.svh"

module ffba_engine
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  q_item_t            q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [15:0]        result_addr,
    output logic [CNT_W-1:0]   blocks_in_use
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_OPEN_RD, S_OPEN_WR, S_SPLIT_NEW, S_SPLIT_HIT,
        S_NXT_RD, S_NXT_CHK, S_MERGE, S_DN_RD, S_DN_WR, S_FIN
    } state_t;

    blk_t                tbl_mem [MAX_BLOCKS];
    blk_t                rd_reg;
    logic                mem_we;
    logic [TBL_AW-1:0]   mem_waddr;
    blk_t                mem_wdata;
    logic [TBL_AW-1:0]   mem_raddr;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [1:0]          rm_reg, rm_next;
    q_item_t             op_reg, op_next;
    blk_t                cur_reg, cur_next;
    blk_t                prev_reg, prev_next;
    logic [SZ_W-1:0]     rest_reg, rest_next;
    status_t             st_reg, st_next;
    logic [15:0]         addr_reg, addr_next;
    logic                ov_reg, ov_next;
    logic [2:0]          ost_reg, ost_next;
    logic [15:0]         oaddr_reg, oaddr_next;
    logic [CNT_W-1:0]    ocnt_reg, ocnt_next;

    logic [SZ_W:0]       need_hdr;
    logic [SZ_W:0]       start;
    logic [SZ_W+1:0]     end_sum;
    logic [SZ_W:0]       pay_off;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W:0]      k_far;

    assign out_valid     = ov_reg;
    assign status        = ost_reg;
    assign result_addr   = oaddr_reg;
    assign blocks_in_use = ocnt_reg;

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        rm_next    = rm_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        rest_next  = rest_reg;
        st_next    = st_reg;
        addr_next  = addr_reg;
        ov_next    = ov_reg && !out_ready;
        ost_next   = ost_reg;
        oaddr_next = oaddr_reg;
        ocnt_next  = ocnt_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[TBL_AW-1:0];
        mem_wdata  = rd_reg;
        mem_raddr  = idx_reg[TBL_AW-1:0];

        idx_inc  = idx_reg + 1'b1;
        need_hdr = {1'b0, op_reg.need} + (SZ_W+1)'(HEADER_BYTES);
        start    = {1'b0, rd_reg.offset} + (SZ_W+1)'(HEADER_BYTES) + {1'b0, rd_reg.size};
        end_sum  = {1'b0, start} + (SZ_W+2)'(HEADER_BYTES) + (SZ_W+2)'(op_reg.need);
        pay_off  = {1'b0, rd_reg.offset} + (SZ_W+1)'(HEADER_BYTES);
        k_far    = {1'b0, k_reg} + (CNT_W+1)'(rm_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_item;
                    idx_next  = '0;
                    addr_next = '0;
                    if (total_reg == '0)
                    begin
                        state_next = S_FIN;
                        if (q_item.cmd == CMD_FREE)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if ({1'b0, q_item.need} + (SZ_W+1)'(HEADER_BYTES) <=
                                 (SZ_W+1)'(HEAP_BYTES - HEAP_HEADER_BYTES))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = '{offset: SZ_W'(HEAP_HEADER_BYTES),
                                          size: q_item.need, is_free: 1'b0};
                            total_next = CNT_W'(1);
                            addr_next  = 16'(HEAP_HEADER_BYTES + HEADER_BYTES);
                            st_next    = ST_OK;
                        end
                        else
                        begin
                            st_next = ST_NOSPACE;
                        end
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (op_reg.cmd == CMD_ALLOC)
                begin
                    if (rd_reg.is_free && rd_reg.size >= op_reg.need)
                    begin
                        if (rd_reg.size == op_reg.need || {1'b0, rd_reg.size} < need_hdr)
                        begin
                            // Too little surplus for a header: take the whole block.
                            mem_we     = 1'b1;
                            mem_wdata  = '{offset: rd_reg.offset, size: rd_reg.size,
                                          is_free: 1'b0};
                            addr_next  = pay_off[15:0];
                            st_next    = ST_OK;
                            state_next = S_FIN;
                        end
                        else if (idx_inc < total_reg)
                        begin
                            if (total_reg >= CNT_W'(MAX_BLOCKS))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cur_next   = rd_reg;
                                rest_next  = rd_reg.size - op_reg.need - SZ_W'(HEADER_BYTES);
                                k_next     = total_reg;
                                state_next = S_OPEN_RD;
                            end
                        end
                        else
                        begin
                            // The last block shrinks and its surplus is dropped.
                            mem_we     = 1'b1;
                            mem_wdata  = '{offset: rd_reg.offset, size: op_reg.need,
                                          is_free: 1'b0};
                            addr_next  = pay_off[15:0];
                            st_next    = ST_OK;
                            state_next = S_FIN;
                        end
                    end
                    else if (idx_inc == total_reg)
                    begin
                        state_next = S_FIN;
                        if (end_sum > (SZ_W+2)'(HEAP_BYTES - 1))
                        begin
                            st_next = ST_NOSPACE;
                        end
                        else if (total_reg >= CNT_W'(MAX_BLOCKS))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = total_reg[TBL_AW-1:0];
                            mem_wdata  = '{offset: start[SZ_W-1:0], size: op_reg.need,
                                          is_free: 1'b0};
                            total_next = total_reg + 1'b1;
                            addr_next  = 16'(start + (SZ_W+1)'(HEADER_BYTES));
                            st_next    = ST_OK;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (pay_off == (SZ_W+1)'(op_reg.paddr))
                    begin
                        if (rd_reg.is_free)
                        begin
                            st_next    = ST_DOUBLE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cur_next   = '{offset: rd_reg.offset, size: rd_reg.size,
                                          is_free: 1'b1};
                            rm_next    = 2'd0;
                            state_next = (idx_inc < total_reg) ? S_NXT_RD : S_MERGE;
                        end
                    end
                    else if (idx_inc == total_reg)
                    begin
                        st_next    = ST_INVALID;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        prev_next  = rd_reg;
                        idx_next   = idx_inc;
                        state_next = S_RD;
                    end
                end
            end

            S_OPEN_RD:
            begin
                mem_raddr  = TBL_AW'(k_reg - 1'b1);
                state_next = S_OPEN_WR;
            end

            S_OPEN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[TBL_AW-1:0];
                mem_wdata = rd_reg;
                k_next    = k_reg - 1'b1;
                state_next = (k_reg - 1'b1 > idx_inc) ? S_OPEN_RD : S_SPLIT_NEW;
            end

            S_SPLIT_NEW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_inc[TBL_AW-1:0];
                mem_wdata  = '{offset: cur_reg.offset + op_reg.need + SZ_W'(HEADER_BYTES),
                              size: rest_reg, is_free: 1'b1};
                state_next = S_SPLIT_HIT;
            end

            S_SPLIT_HIT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '{offset: cur_reg.offset, size: op_reg.need, is_free: 1'b0};
                total_next = total_reg + 1'b1;
                addr_next  = 16'(cur_reg.offset + SZ_W'(HEADER_BYTES));
                st_next    = ST_OK;
                state_next = S_FIN;
            end

            S_NXT_RD:
            begin
                mem_raddr  = idx_inc[TBL_AW-1:0];
                state_next = S_NXT_CHK;
            end

            S_NXT_CHK:
            begin
                if (rd_reg.is_free)
                begin
                    cur_next.size = cur_reg.size + rd_reg.size + SZ_W'(HEADER_BYTES);
                    rm_next       = 2'd1;
                end
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                // Write the surviving block, then close the gap of merged entries.
                mem_we = 1'b1;
                if (idx_reg != '0 && prev_reg.is_free)
                begin
                    mem_waddr = TBL_AW'(idx_reg - 1'b1);
                    mem_wdata = '{offset: prev_reg.offset,
                                 size: prev_reg.size + cur_reg.size + SZ_W'(HEADER_BYTES),
                                 is_free: 1'b1};
                    k_next    = idx_reg;
                    rm_next   = rm_reg + 2'd1;
                end
                else
                begin
                    mem_wdata = cur_reg;
                    k_next    = idx_inc;
                end
                state_next = S_DN_RD;
            end

            S_DN_RD:
            begin
                mem_raddr = k_far[TBL_AW-1:0];
                if (k_far < (CNT_W+1)'(total_reg))
                begin
                    state_next = S_DN_WR;
                end
                else
                begin
                    total_next = total_reg - CNT_W'(rm_reg);
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
            end

            S_DN_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = k_reg[TBL_AW-1:0];
                mem_wdata  = rd_reg;
                k_next     = k_reg + 1'b1;
                state_next = S_DN_RD;
            end

            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    oaddr_next = addr_reg;
                    ocnt_next  = total_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= tbl_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        rm_reg    <= rm_next;
        op_reg    <= op_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        rest_reg  <= rest_next;
        st_reg    <= st_next;
        addr_reg  <= addr_next;
        ost_reg   <= ost_next;
        oaddr_reg <= oaddr_next;
        ocnt_reg  <= ocnt_next;
    end

    `FFBA_ASSERT(a_total_bound, total_reg <= CNT_W'(MAX_BLOCKS), "block count beyond table")
    `FFBA_IMPLY(a_fail_zero, ov_reg && ost_reg != ST_OK, oaddr_reg == 16'd0,
        "failed transaction carries an address")
    `FFBA_IMPLY(a_pop_idle, q_pop, state_reg == S_IDLE, "command taken while busy")

endmodule

/* sv/first_fit_block_allocator.sv */
// Channel   Handshake             Payload
// input     in_valid / in_ready   cmd, req_size, payload_addr
// output    out_valid / out_ready status, result_addr, blocks_in_use
//
// A command reads and checks the table entries one by one until it finds its
// block, and moves entries when a split opens a slot or a free rewrites the
// entries behind the freed block; each entry moved is first read and then
// written, as the table memory has registered reads.
// Reset (rst_n low, asynchronous) empties the table, the queue and the output.
// A two-entry queue takes commands while the engine works, and a finished
// result waits in the output register without holding back the next command.

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [15:0]        req_size,
    input  logic [15:0]        payload_addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [15:0]        result_addr,
    output logic [CNT_W-1:0]   blocks_in_use
);

    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    ffba_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .req_size     (req_size),
        .payload_addr (payload_addr),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    ffba_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_addr   (result_addr),
        .blocks_in_use (blocks_in_use)
    );

endmodule
